[rtl/ulf_pkg.sv]
`timescale 1ns / 1ps

package ulf_pkg;

  // Command classes handed from the front end to the execution unit
  typedef enum logic [1:0] {
    OP_PUSH    = 2'd0,
    OP_PROCESS = 2'd1,
    OP_TAKE    = 2'd2,
    OP_NOP     = 2'd3
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] data;
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DRAIN_RD,
    ST_DRAIN_WR,
    ST_TAKE_RD,
    ST_TAKE_OUT
  } back_state_t;

  // One result, as it leaves the output register
  typedef struct packed {
    logic       last;
    logic       char_valid;
    logic [7:0] char_out;
    logic [6:0] line_length;
    logic       line_ready;
    logic       accepted;
  } res_t;

  localparam int unsigned KindW   = 2;
  localparam int unsigned OutDataW = 24;

  localparam logic [7:0] CHAR_LF   = 8'h0A;
  localparam logic [7:0] CHAR_CR   = 8'h0D;
  localparam logic [7:0] CHAR_SEMI = 8'h3B;
  localparam logic [7:0] CHAR_QM   = 8'h3F;
  localparam logic [7:0] CHAR_NUL  = 8'h00;

endpackage

[rtl/uart_rx_ring_line_framer_top.sv]
`timescale 1ns / 1ps
// Channel | Dir | tdata (low bit first)                          | tuser      | tlast
// in_     | in  | [7:0] data_byte                                | [1:0] kind | -
// out_    | out | [0] accepted [1] line_ready [8:2] line_length  | [0] char_  | last
//         |     | [16:9] char_out, [23:17] zero                  |    valid   |
// Flow: a received byte, a status reply or a take on no line passes through the command queue
//   and the execution unit; a process drains the ring byte by byte, each byte read from the
//   registered ring memory and then written to the line; a take reads each line character
//   from the registered line memory before it is emitted.
// Reset: rst_n synchronous, active low; ring empty, line empty, ready flag clear.
// Stalls: the command queue takes up to two transactions while the output register holds.

module uart_rx_ring_line_framer_top import ulf_pkg::*; #(
  parameter int unsigned RING_SLOTS = 64,
  parameter int unsigned LINE_LEN   = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [7:0]          in_tdata,   // [7:0] data_byte
  input  logic [KindW-1:0]    in_tuser,   // [1:0] kind
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [OutDataW-1:0] out_tdata,  // accepted, line_ready, line_length, char_out
  output logic                out_tuser,  // [0] char_valid
  output logic                out_tlast
);

  logic cmd_valid;
  logic cmd_ready;
  cmd_t cmd;
  res_t res;

  // Front end: classify each transaction and queue it
  ulf_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd)
  );

  // Execution unit: ring, line store, output register
  ulf_back #(
    .RING_SLOTS (RING_SLOTS),
    .LINE_LEN   (LINE_LEN)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .res       (res)
  );

  // Pack the result fields, lowest field first, padded with zeros to 24 bits
  assign out_tdata = {7'd0, res.char_out, res.line_length, res.line_ready, res.accepted};
  assign out_tuser = res.char_valid;
  assign out_tlast = res.last;

endmodule

[rtl/ulf_front.sv]
`timescale 1ns / 1ps

module ulf_front import ulf_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [7:0]       in_tdata,
  input  logic [KindW-1:0] in_tuser,
  output logic             cmd_valid,
  input  logic             cmd_ready,
  output cmd_t             cmd
);

  // two-entry command queue
  cmd_t       q_r [2];
  logic       wp_r, wp_nxt;
  logic       rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push, pop;
  cmd_t       cmd_in;

  always_comb begin
    unique case (in_tuser)
      2'd0:    cmd_in.op = OP_PUSH;
      2'd1:    cmd_in.op = OP_PROCESS;
      2'd2:    cmd_in.op = OP_TAKE;
      default: cmd_in.op = OP_NOP;
    endcase
    cmd_in.data = in_tdata;
  end

  assign in_tready = (cnt_r != 2'd2);
  assign cmd_valid = (cnt_r != 2'd0);
  assign cmd       = q_r[rp_r];
  assign push      = in_tvalid && in_tready;
  assign pop       = cmd_valid && cmd_ready;

  always_comb begin
    wp_nxt  = push ? ~wp_r : wp_r;
    rp_nxt  = pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wp_r] <= cmd_in;
    end
  end

endmodule

[rtl/ulf_back.sv]
`timescale 1ns / 1ps

module ulf_back import ulf_pkg::*; #(
  parameter int unsigned RING_SLOTS = 64,
  parameter int unsigned LINE_LEN   = 32
) (
  input  logic clk,
  input  logic rst_n,
  input  logic cmd_valid,
  output logic cmd_ready,
  input  cmd_t cmd,
  output logic out_valid,
  input  logic out_ready,
  output res_t res
);

  localparam int unsigned PW = (RING_SLOTS > 1) ? $clog2(RING_SLOTS) : 1;
  localparam int unsigned CW = $clog2(LINE_LEN + 1);
  localparam int unsigned LW = (LINE_LEN > 1) ? $clog2(LINE_LEN) : 1;

  logic [7:0]  ring_mem [RING_SLOTS];
  logic [7:0]  line_mem [LINE_LEN];
  logic [7:0]  ring_q_r;
  logic [7:0]  line_q_r;

  back_state_t state_r, state_nxt;
  logic [PW-1:0] rd_r, rd_nxt;
  logic [PW-1:0] wr_r, wr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] idx_r, idx_nxt;
  logic          ready_r, ready_nxt;
  logic          out_valid_r;
  res_t          res_r, res_nxt;
  logic          emit, can_emit, ring_we, line_we;
  logic          full_line, is_term;
  logic [PW-1:0] wr_next_slot, rd_next_slot;

  assign can_emit     = !out_valid_r || out_ready;
  assign wr_next_slot = (wr_r == PW'(RING_SLOTS - 1)) ? '0 : wr_r + PW'(1);
  assign rd_next_slot = (rd_r == PW'(RING_SLOTS - 1)) ? '0 : rd_r + PW'(1);
  assign full_line    = (count_r >= CW'(LINE_LEN));
  assign is_term      = (ring_q_r == CHAR_LF) || (ring_q_r == CHAR_CR) ||
                        (ring_q_r == CHAR_SEMI) || (ring_q_r == CHAR_QM);

  always_comb begin
    state_nxt = state_r;
    rd_nxt    = rd_r;
    wr_nxt    = wr_r;
    count_nxt = count_r;
    idx_nxt   = idx_r;
    ready_nxt = ready_r;
    emit      = 1'b0;
    res_nxt   = '0;
    ring_we   = 1'b0;
    line_we   = 1'b0;
    cmd_ready = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (cmd_valid && can_emit) begin
          cmd_ready = 1'b1;
          unique case (cmd.op)
            OP_PUSH: begin
              if (wr_next_slot != rd_r) begin
                ring_we          = 1'b1;
                wr_nxt           = wr_next_slot;
                res_nxt.accepted = 1'b1;
              end
              emit                = 1'b1;
              res_nxt.line_ready  = ready_r;
              res_nxt.line_length = 7'(count_r);
              res_nxt.last        = 1'b1;
            end
            OP_PROCESS: begin
              if (ready_r) begin
                emit                = 1'b1;
                res_nxt.line_ready  = 1'b1;
                res_nxt.line_length = 7'(count_r);
                res_nxt.last        = 1'b1;
              end else begin
                state_nxt = ST_DRAIN_RD;
              end
            end
            OP_TAKE: begin
              if (!ready_r) begin
                emit                = 1'b1;
                res_nxt.line_length = 7'(count_r);
                res_nxt.last        = 1'b1;
              end else if (count_r == '0) begin
                ready_nxt    = 1'b0;
                emit         = 1'b1;
                res_nxt.last = 1'b1;
              end else begin
                idx_nxt   = '0;
                state_nxt = ST_TAKE_RD;
              end
            end
            OP_NOP: begin
              emit                = 1'b1;
              res_nxt.line_ready  = ready_r;
              res_nxt.line_length = 7'(count_r);
              res_nxt.last        = 1'b1;
            end
            default: ;
          endcase
        end
      end
      ST_DRAIN_RD: begin
        if (ready_r || (rd_r == wr_r) || full_line) begin
          if (can_emit) begin
            ready_nxt           = ready_r || full_line;
            emit                = 1'b1;
            res_nxt.line_ready  = ready_r || full_line;
            res_nxt.line_length = 7'(count_r);
            res_nxt.last        = 1'b1;
            state_nxt           = ST_IDLE;
          end
        end else begin
          rd_nxt    = rd_next_slot;
          state_nxt = ST_DRAIN_WR;
        end
      end
      ST_DRAIN_WR: begin
        // drop zero bytes, append everything else
        if (ring_q_r != CHAR_NUL) begin
          line_we   = 1'b1;
          count_nxt = count_r + CW'(1);
        end
        if (is_term) begin
          ready_nxt = 1'b1;
        end
        state_nxt = ST_DRAIN_RD;
      end
      ST_TAKE_RD: begin
        state_nxt = ST_TAKE_OUT;
      end
      ST_TAKE_OUT: begin
        if (can_emit) begin
          emit               = 1'b1;
          res_nxt.char_out   = line_q_r;
          res_nxt.char_valid = 1'b1;
          if (idx_r == count_r - CW'(1)) begin
            res_nxt.last = 1'b1;
            ready_nxt    = 1'b0;
            count_nxt    = '0;
            state_nxt    = ST_IDLE;
          end else begin
            res_nxt.line_ready  = 1'b1;
            res_nxt.line_length = 7'(count_r);
            idx_nxt             = idx_r + CW'(1);
            state_nxt           = ST_TAKE_RD;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      rd_r        <= '0;
      wr_r        <= '0;
      count_r     <= '0;
      idx_r       <= '0;
      ready_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      rd_r    <= rd_nxt;
      wr_r    <= wr_nxt;
      count_r <= count_nxt;
      idx_r   <= idx_nxt;
      ready_r <= ready_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      res_r <= res_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ring_we) begin
      ring_mem[wr_r] <= cmd.data;
    end
    ring_q_r <= ring_mem[rd_r];
  end

  always_ff @(posedge clk) begin
    if (line_we) begin
      line_mem[count_r[LW-1:0]] <= ring_q_r;
    end
    line_q_r <= line_mem[idx_r[LW-1:0]];
  end

  assign out_valid = out_valid_r;
  assign res       = res_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(LINE_LEN))
    else $error("line count beyond line size");

  a_take_state: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_TAKE_RD || state_r == ST_TAKE_OUT) |-> (ready_r && count_r != '0))
    else $error("line output without a finished line");

  a_nonlast_is_char: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !res_r.last) |-> res_r.char_valid)
    else $error("non-final result without a character");

  a_drain_clears_on_take: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_TAKE_OUT && emit && res_nxt.last) |=> (count_r == '0 && !ready_r))
    else $error("line not cleared after output");

endmodule

[tb/sv/tb_uart_rx_ring_line_framer_top.sv]
`timescale 1ns / 1ps

module tb_uart_rx_ring_line_framer_top import ulf_pkg::*;;

  localparam int unsigned RING_SLOTS = 64;
  localparam int unsigned LINE_LEN   = 32;
  // Longest quiet stretch the block needs once the last transaction is in:
  // a full take reads each character from the line memory and then emits it, plus queue and output stages.
  localparam int unsigned SETTLE_CYCLES = 200;

  // One reply of the framer, in the order the fields sit on the output bus.
  typedef struct packed {
    logic       accepted;
    logic       line_ready;
    logic [6:0] line_length;
    logic [7:0] char_out;
    logic       char_valid;
    logic       last;
  } framer_reply_t;

  logic                clk        = 1'b0;
  logic                rst_n      = 1'b0;
  logic                in_tvalid  = 1'b0;
  logic                in_tready;
  logic [7:0]          in_tdata   = '0;   // [7:0] data_byte
  logic [KindW-1:0]    in_tuser   = '0;   // [1:0] kind
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  logic [OutDataW-1:0] out_tdata;         // [0] accepted [1] line_ready [8:2] line_length
                                          // [16:9] char_out, rest zero
  logic                out_tuser;         // [0] char_valid
  logic                out_tlast;

  // Shadow copy of the receive ring and the line being assembled.
  logic [7:0]    ring_copy [RING_SLOTS];
  int unsigned   ring_head    = 0;
  int unsigned   ring_tail    = 0;
  logic [7:0]    line_copy [LINE_LEN];
  int unsigned   line_fill    = 0;
  bit            line_done    = 1'b0;

  framer_reply_t owed_replies[$];
  int unsigned   reply_errors = 0;
  int unsigned   cmds_sent    = 0;

  // Traffic shaping knobs, changed by the tests between phases.
  int unsigned   src_idle_pct   = 0;
  int unsigned   sink_stall_pct = 0;
  int unsigned   hold_req       = 0;
  int unsigned   hold_left      = 0;

  uart_rx_ring_line_framer_top #(
    .RING_SLOTS(RING_SLOTS),
    .LINE_LEN  (LINE_LEN)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Hard stop in case the block locks up.
  initial begin
    #2_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // Work out the replies one command causes and queue them in order.
  task automatic predict_replies(op_t op, logic [7:0] byte_in);
    framer_reply_t r;
    framer_reply_t ch;
    int unsigned   nxt;
    logic [7:0]    c;
    int unsigned   i;
    r      = '0;
    r.last = 1'b1;
    case (op)
      OP_PUSH: begin
        // One slot always stays free, so a full ring drops the byte.
        nxt = (ring_tail + 1) % RING_SLOTS;
        if (nxt != ring_head) begin
          ring_copy[ring_tail] = byte_in;
          ring_tail            = nxt;
          r.accepted           = 1'b1;
        end
      end
      OP_PROCESS: begin
        if (!line_done) begin
          while (ring_head != ring_tail && line_fill < LINE_LEN) begin
            c         = ring_copy[ring_head];
            ring_head = (ring_head + 1) % RING_SLOTS;
            // Drop zero bytes without ending the line.
            if (c != CHAR_NUL) begin
              line_copy[line_fill] = c;
              line_fill++;
            end
            if (c == CHAR_LF || c == CHAR_CR || c == CHAR_SEMI || c == CHAR_QM) begin
              line_done = 1'b1;
              break;
            end
          end
          if (line_fill >= LINE_LEN) line_done = 1'b1;
        end
      end
      OP_TAKE: begin
        if (line_done) begin
          if (line_fill != 0) begin
            for (i = 0; i + 1 < line_fill; i++) begin
              ch             = '0;
              ch.line_ready  = 1'b1;
              ch.line_length = line_fill[6:0];
              ch.char_out    = line_copy[i];
              ch.char_valid  = 1'b1;
              owed_replies.push_back(ch);
            end
            r.char_out   = line_copy[line_fill - 1];
            r.char_valid = 1'b1;
            line_fill    = 0;
          end
          line_done = 1'b0;
        end
      end
      default: begin
      end
    endcase
    r.line_ready  = line_done;
    r.line_length = line_fill[6:0];
    owed_replies.push_back(r);
  endtask

  // Offer one command, hold it until the handshake, then idle as configured.
  task automatic send_cmd(op_t op, logic [7:0] byte_in);
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= byte_in;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_replies(op, byte_in);
    if (op != OP_NOP) cmds_sent++;
    while (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
  endtask

  // Pause the source until every owed reply has come back.
  task automatic wait_all_replies();
    in_tvalid <= 1'b0;
    while (owed_replies.size() != 0) @(posedge clk);
  endtask

  // Receiver: a requested hold-off wins, otherwise stall at random.
  always @(posedge clk) begin
    if (hold_req != 0) begin
      hold_left = hold_req;
      hold_req  = 0;
    end
    if (hold_left != 0) begin
      out_tready <= 1'b0;
      hold_left--;
    end else begin
      out_tready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  // Compare every reply transaction against the oldest owed reply.
  always @(posedge clk) begin : check_replies
    framer_reply_t got;
    framer_reply_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got.accepted    = out_tdata[0];
      got.line_ready  = out_tdata[1];
      got.line_length = out_tdata[8:2];
      got.char_out    = out_tdata[16:9];
      got.char_valid  = out_tuser;
      got.last        = out_tlast;
      if (owed_replies.size() == 0) begin
        reply_errors++;
        if (reply_errors <= 10)
          $display("%0t: reply with none owed: acc=%0d rdy=%0d len=%0d ch=%02h cv=%0d last=%0d",
                   $realtime, got.accepted, got.line_ready, got.line_length, got.char_out,
                   got.char_valid, got.last);
      end else begin
        want = owed_replies.pop_front();
        if (got.accepted !== want.accepted || got.line_ready !== want.line_ready ||
            got.line_length !== want.line_length || got.char_out !== want.char_out ||
            got.char_valid !== want.char_valid || got.last !== want.last) begin
          reply_errors++;
          if (reply_errors <= 10) begin
            $write("%0t: reply mismatch: expected acc=%0d rdy=%0d len=%0d ch=%02h cv=%0d ",
                   $realtime, want.accepted, want.line_ready, want.line_length,
                   want.char_out, want.char_valid);
            $display("last=%0d, got acc=%0d rdy=%0d len=%0d ch=%02h cv=%0d last=%0d",
                     want.last, got.accepted, got.line_ready, got.line_length,
                     got.char_out, got.char_valid, got.last);
          end
        end
      end
    end
  end

  // Walk each terminator, zero and 0xFF bytes, a process while a line waits,
  // a take with no line and the ignored kind.
  task automatic test_corner_cases();
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    send_cmd(OP_TAKE, 8'h00);
    send_cmd(OP_PROCESS, 8'h00);
    send_cmd(OP_NOP, 8'hFF);
    send_cmd(OP_PUSH, 8'h41);
    send_cmd(OP_PUSH, CHAR_NUL);
    send_cmd(OP_PUSH, 8'hFF);
    send_cmd(OP_PUSH, CHAR_LF);
    send_cmd(OP_PROCESS, 8'h00);
    send_cmd(OP_PUSH, CHAR_CR);
    send_cmd(OP_PROCESS, 8'h00);
    send_cmd(OP_TAKE, 8'h00);
    send_cmd(OP_PROCESS, 8'h00);
    send_cmd(OP_TAKE, 8'h00);
    send_cmd(OP_PUSH, CHAR_SEMI);
    send_cmd(OP_PROCESS, 8'hFF);
    send_cmd(OP_TAKE, 8'hFF);
    send_cmd(OP_PUSH, CHAR_QM);
    send_cmd(OP_PROCESS, 8'h00);
    send_cmd(OP_TAKE, 8'h00);
  endtask

  // Hold the receiver off while pushing past a full ring, so the command
  // queue backs up; then assemble a full line, take it, and drain the rest.
  task automatic test_ring_overflow_under_hold();
    int unsigned k;
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    hold_req       = 500;
    for (k = 0; k < 70; k++) send_cmd(OP_PUSH, 8'(8'h61 + k % 26));
    send_cmd(OP_PROCESS, 8'h00);
    send_cmd(OP_TAKE, 8'h00);
    send_cmd(OP_PROCESS, 8'h00);
    send_cmd(OP_PUSH, CHAR_LF);
    send_cmd(OP_PROCESS, 8'h00);
    send_cmd(OP_TAKE, 8'h00);
    wait_all_replies();
  endtask

  // Mostly well-formed lines with random content, plus bursts and noise.
  task automatic test_random_traffic(int unsigned idle_pct, int unsigned stall_pct,
                                     int unsigned n_cmds);
    int unsigned goal;
    int unsigned n;
    int unsigned k;
    int unsigned pick;
    logic [7:0]  c;
    src_idle_pct   = idle_pct;
    sink_stall_pct = stall_pct;
    goal           = cmds_sent + n_cmds;
    while (cmds_sent < goal) begin
      pick = $urandom_range(99);
      if (pick < 60) begin
        n = ($urandom_range(9) == 0) ? $urandom_range(45) : $urandom_range(12);
        for (k = 0; k < n; k++) begin
          case ($urandom_range(19))
            0:       c = CHAR_NUL;
            1:       c = 8'($urandom_range(255));
            default: c = 8'($urandom_range(8'h7A, 8'h41));
          endcase
          send_cmd(OP_PUSH, c);
        end
        case ($urandom_range(9))
          0:       ;                               // leave the line open
          1, 2:    send_cmd(OP_PUSH, CHAR_LF);
          3, 4:    send_cmd(OP_PUSH, CHAR_CR);
          5, 6:    send_cmd(OP_PUSH, CHAR_SEMI);
          default: send_cmd(OP_PUSH, CHAR_QM);
        endcase
        repeat ($urandom_range(2, 1)) send_cmd(OP_PROCESS, 8'($urandom_range(255)));
        send_cmd(OP_TAKE, 8'($urandom_range(255)));
        if ($urandom_range(4) == 0) send_cmd(OP_TAKE, 8'($urandom_range(255)));
      end else if (pick < 75) begin
        repeat ($urandom_range(70, 20)) send_cmd(OP_PUSH, 8'($urandom_range(255)));
        repeat ($urandom_range(3, 1)) begin
          send_cmd(OP_PROCESS, 8'($urandom_range(255)));
          send_cmd(OP_TAKE, 8'($urandom_range(255)));
        end
      end else begin
        repeat ($urandom_range(4, 1))
          send_cmd(op_t'($urandom_range(3)), 8'($urandom_range(255)));
      end
    end
  endtask

  initial begin
    int unsigned guard;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_corner_cases();
    test_ring_overflow_under_hold();
    test_random_traffic(0, 0, 65);
    test_random_traffic(50, 0, 65);
    test_random_traffic(0, 50, 65);
    test_random_traffic(38, 38, 65);

    in_tvalid <= 1'b0;
    guard = 0;
    while (owed_replies.size() != 0 && guard < 100_000) begin
      @(posedge clk);
      guard++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (owed_replies.size() != 0) begin
      reply_errors += owed_replies.size();
      $display("%0t: %0d replies never arrived", $realtime, owed_replies.size());
    end

    if (reply_errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
